>>> hdl/evad_pkg.sv
package evad_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int CHUNK_W    = 11;
   localparam int LANE_W     = 26;
   localparam int SUM_W      = LANE_W + 1;
   localparam int AVG_W      = 17;
   localparam int THR_W      = 16;
   localparam int FLUSH_W    = 16;
   localparam int BREAK_W    = 20;
   localparam int TIMEOUT_W  = 16;
   localparam int BUF_W      = 24;
   localparam int SINCE_W    = 21;
   localparam int TICK_W     = 16;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 20;
   localparam int MAX_EVENTS = 4;
   localparam int EV_CNT_W   = 3;
   localparam int EV_IDX_W   = 2;

   localparam int DEF_MAX_CHUNK_FRAMES = 1024;

   localparam logic [KIND_W-1:0] EV_START = 2'd0;
   localparam logic [KIND_W-1:0] EV_FLUSH = 2'd1;
   localparam logic [KIND_W-1:0] EV_BREAK = 2'd2;
   localparam logic [KIND_W-1:0] EV_END   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_VOICE_THRESHOLD = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FLUSH_FRAMES    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BREAK_FRAMES    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT_TICKS   = 8'd3;

   localparam logic [THR_W-1:0]     RST_VOICE_THRESHOLD = 16'd1000;
   localparam logic [FLUSH_W-1:0]   RST_FLUSH_FRAMES    = 16'd2048;
   localparam logic [BREAK_W-1:0]   RST_BREAK_FRAMES    = 20'd40000;
   localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT_TICKS   = 16'd800;

   typedef struct packed {
      logic [THR_W-1:0]     voice_threshold;
      logic [FLUSH_W-1:0]   flush_frames;
      logic [BREAK_W-1:0]   break_frames;
      logic [TIMEOUT_W-1:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BUF_W-1:0]  frames;
      logic [AVG_W-1:0]  average;
   } event_type;

   typedef struct packed {
      logic               done;
      logic               busy;
      logic [CHUNK_W-1:0] frames;
      logic [AVG_W-1:0]   average;
   } div_result_type;

endpackage

>>> hdl/evad_req_if.sv
interface evad_req_if;
   import evad_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       func;
   logic signed [SAMPLE_W-1:0] sample_left;
   logic signed [SAMPLE_W-1:0] sample_right;
   logic                       chunk_end;

   modport source (output valid, func, sample_left, sample_right, chunk_end, input ready);
   modport sink   (input valid, func, sample_left, sample_right, chunk_end, output ready);
endinterface

>>> hdl/evad_rsp_if.sv
interface evad_rsp_if;
   import evad_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] event_kind;
   logic [BUF_W-1:0]  flushed_frames;
   logic [AVG_W-1:0]  chunk_average;
   logic              last_event;

   modport source (output valid, event_kind, flushed_frames, chunk_average, last_event,
                   input ready);
   modport sink   (input valid, event_kind, flushed_frames, chunk_average, last_event,
                   output ready);
endinterface

>>> hdl/evad_csr_if.sv
interface evad_csr_if;
   import evad_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/evad_lane.sv
module evad_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                acc_en,
   input  logic                                clear,
   input  logic signed [evad_pkg::SAMPLE_W-1:0] sample,
   output logic [evad_pkg::LANE_W-1:0]         sum_in
);
   import evad_pkg::*;

   logic [LANE_W-1:0]   sum_ff;
   logic [SAMPLE_W:0]   mag;

   // magnitude of a two's complement sample; the most negative value gives 2^15
   always_comb begin
      if (sample[SAMPLE_W-1]) begin
         mag = (SAMPLE_W+1)'(1 << SAMPLE_W) - {1'b0, sample};
      end else begin
         mag = {1'b0, sample};
      end
   end

   assign sum_in = sum_ff + LANE_W'(mag);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (acc_en) begin
         sum_ff <= clear ? '0 : sum_in;
      end
   end

endmodule

>>> hdl/evad_div.sv
module evad_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [evad_pkg::SUM_W-1:0]    dividend,
   input  logic [evad_pkg::CHUNK_W-1:0]  divisor,
   output evad_pkg::div_result_type      result
);
   import evad_pkg::*;

   localparam int ITER_W = $clog2(SUM_W);

   logic [SUM_W-1:0]   dvd_ff, dvd_in;
   logic [CHUNK_W-1:0] rem_ff, rem_in;
   logic [CHUNK_W-1:0] div_ff;
   logic [ITER_W-1:0]  cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [CHUNK_W:0]   shift;
   logic [CHUNK_W:0]   diff;
   logic               fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      shift  = {rem_ff, dvd_ff[SUM_W-1]};
      diff   = shift - {1'b0, div_ff};
      fits   = shift >= {1'b0, div_ff};
      rem_in = fits ? diff[CHUNK_W-1:0] : shift[CHUNK_W-1:0];
      dvd_in = {dvd_ff[SUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= ITER_W'(SUM_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   // the quotient never exceeds 2^16 since each frame adds at most 2^16
   assign result.done    = done_ff;
   assign result.busy    = busy_ff;
   assign result.frames  = div_ff;
   assign result.average = dvd_ff[AVG_W-1:0];

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff && !done_ff)
      else $error("divider restarted while busy");
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held for more than one cycle");

endmodule

>>> hdl/evad_events.sv
module evad_events (
   input  logic                      clock,
   input  logic                      reset,
   input  evad_pkg::cfg_type         cfg,
   input  logic                      tick,
   input  evad_pkg::div_result_type  div_res,
   output logic                      busy,
   evad_rsp_if.source                rsp_bus
);
   import evad_pkg::*;

   logic                 act_ff, act_in;
   logic [BUF_W-1:0]     buffered_ff, buffered_in;
   logic [SINCE_W-1:0]   since_ff, since_in;
   logic [TICK_W-1:0]    silence_ff, silence_in, silence_tick;
   logic                 pending_ff;
   logic [EV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [EV_CNT_W-1:0]  rd_ff;
   event_type            list_ff [MAX_EVENTS];
   event_type            list_in [MAX_EVENTS];
   event_type            out_ff;
   logic                 out_valid_ff;
   logic                 out_last_ff;
   logic                 eval;
   logic                 load;

   logic [BUF_W:0]       buf_sum;
   logic [BUF_W-1:0]     buf_add;
   logic [SINCE_W:0]     since_sum;
   logic [SINCE_W-1:0]   since_add;
   logic [THR_W+1:0]     thr3;
   logic [THR_W-2:0]     thr38;
   logic                 voice, act1, flush, brk, timeout;
   logic [TICK_W-1:0]    sil1;
   logic [AVG_W-1:0]     avg;

   assign avg = div_res.average;
   assign silence_tick = (silence_ff == '1) ? silence_ff : silence_ff + 1'b1;

   always_comb begin
      buf_sum   = {1'b0, buffered_ff} + (BUF_W+1)'(div_res.frames);
      buf_add   = buf_sum[BUF_W] ? '1 : buf_sum[BUF_W-1:0];
      since_sum = {1'b0, since_ff} + (SINCE_W+1)'(div_res.frames);
      since_add = since_sum[SINCE_W] ? '1 : since_sum[SINCE_W-1:0];
      thr3      = {2'b00, cfg.voice_threshold} + {1'b0, cfg.voice_threshold, 1'b0};
      thr38     = thr3[THR_W+1:3];

      voice   = avg > {1'b0, cfg.voice_threshold};
      act1    = act_ff | voice;
      sil1    = voice ? '0 : silence_ff;
      flush   = act1 && (buf_add > BUF_W'(cfg.flush_frames));
      brk     = (since_add > SINCE_W'(cfg.break_frames)) && (avg < AVG_W'(thr38));
      timeout = sil1 >= cfg.timeout_ticks;

      for (int i = 0; i < MAX_EVENTS; i++) begin
         list_in[i] = '{kind: EV_START, frames: '0, average: avg};
      end
      cnt_in = '0;
      // events go out in the order start, flush, break, end
      if (voice && !act_ff) begin
         list_in[cnt_in[EV_IDX_W-1:0]].kind = EV_START;
         cnt_in = cnt_in + 1'b1;
      end
      if (flush) begin
         list_in[cnt_in[EV_IDX_W-1:0]].kind   = EV_FLUSH;
         list_in[cnt_in[EV_IDX_W-1:0]].frames = buf_add;
         cnt_in = cnt_in + 1'b1;
      end
      if (brk) begin
         list_in[cnt_in[EV_IDX_W-1:0]].kind = EV_BREAK;
         cnt_in = cnt_in + 1'b1;
      end
      if (timeout && act1) begin
         list_in[cnt_in[EV_IDX_W-1:0]].kind = EV_END;
         cnt_in = cnt_in + 1'b1;
      end

      if (timeout) begin
         act_in      = 1'b0;
         buffered_in = '0;
         since_in    = '0;
         silence_in  = '0;
      end else begin
         act_in      = act1;
         buffered_in = flush ? '0 : buf_add;
         since_in    = brk ? '0 : since_add;
         silence_in  = sil1;
      end
   end

   // evaluate once the previous chunk's events have all moved to the output register
   assign eval = pending_ff && (rd_ff == cnt_ff);
   assign load = (rd_ff < cnt_ff) && (!out_valid_ff || rsp_bus.ready);
   assign busy = pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         buffered_ff  <= '0;
         since_ff     <= '0;
         silence_ff   <= '0;
         pending_ff   <= 1'b0;
         cnt_ff       <= '0;
         rd_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (div_res.done) begin
            pending_ff <= 1'b1;
         end
         if (tick) begin
            silence_ff <= silence_tick;
         end
         if (eval) begin
            pending_ff  <= 1'b0;
            act_ff      <= act_in;
            buffered_ff <= buffered_in;
            since_ff    <= since_in;
            silence_ff  <= silence_in;
            cnt_ff      <= cnt_in;
            rd_ff       <= '0;
         end
         if (load) begin
            out_valid_ff <= 1'b1;
            rd_ff        <= rd_ff + 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (eval) begin
         list_ff <= list_in;
      end
      if (load) begin
         out_ff      <= list_ff[rd_ff[EV_IDX_W-1:0]];
         out_last_ff <= (rd_ff + 1'b1) == cnt_ff;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.event_kind     = out_ff.kind;
   assign rsp_bus.flushed_frames = out_ff.frames;
   assign rsp_bus.chunk_average  = out_ff.average;
   assign rsp_bus.last_event     = out_last_ff;

   a_rd_bound: assert property (@(posedge clock) disable iff (reset)
      rd_ff <= cnt_ff && cnt_ff <= EV_CNT_W'(MAX_EVENTS))
      else $error("event read pointer past event count");
   a_no_tick_pending: assert property (@(posedge clock) disable iff (reset)
      tick |-> !pending_ff && !div_res.done)
      else $error("tick taken while a chunk evaluation is open");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> !pending_ff)
      else $error("new average arrived before the previous chunk was evaluated");

endmodule

>>> hdl/energy_voice_activity_detector.sv
// Energy voice activity detector.
// req_bus carries one transaction per stereo sample pair (func 0) or time tick (func 1);
// chunk_end marks the last pair of a capture chunk, and a chunk also ends when it
// reaches MAX_CHUNK_FRAMES pairs. rsp_bus returns zero to four events per chunk
// (start, flush, break, end, in that order), the last one flagged by last_event.
// csr_bus writes the four registers by index; unknown indexes are dropped.
// Pairs inside a chunk and ticks are taken one per cycle. A chunk-end pair starts a
// bit-serial divider over the chunk's amplitude sum, one quotient bit per cycle:
// req_bus.ready stays low through the divide steps, the divider's done strobe and the
// evaluation, and the first event is registered in the event list and then loaded
// into the output register. Events leave through an output register one per cycle;
// a stalled receiver holds the event in place, and the next chunk end waits in
// evaluation until the previous chunk's events have all moved to the output register.
// Synchronous reset restores the register defaults and clears all counters, the
// session flag and pending events.
module energy_voice_activity_detector #(
   parameter int MAX_CHUNK_FRAMES = evad_pkg::DEF_MAX_CHUNK_FRAMES
) (
   input  logic        clock,
   input  logic        reset,
   evad_req_if.sink    req_bus,
   evad_rsp_if.source  rsp_bus,
   evad_csr_if.sink    csr_bus
);
   import evad_pkg::*;

   cfg_type            cfg_ff;
   logic [CHUNK_W-1:0] frames_ff;
   logic [CHUNK_W-1:0] frames_in;
   logic               accept;
   logic               pair;
   logic               tick;
   logic               chunk_done;
   logic [LANE_W-1:0]  left_sum;
   logic [LANE_W-1:0]  right_sum;
   logic [SUM_W-1:0]   chunk_sum;
   div_result_type     div_res;
   logic               ev_busy;

   assign accept     = req_bus.valid && req_bus.ready;
   assign pair       = accept && !req_bus.func;
   assign tick       = accept && req_bus.func;
   assign frames_in  = frames_ff + 1'b1;
   assign chunk_done = req_bus.chunk_end || (frames_in >= CHUNK_W'(MAX_CHUNK_FRAMES));
   assign chunk_sum  = {1'b0, left_sum} + {1'b0, right_sum};

   // hold off input from a chunk end until its evaluation is done
   assign req_bus.ready = !(div_res.busy || div_res.done || ev_busy);
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= '0;
      end else if (pair) begin
         frames_ff <= chunk_done ? '0 : frames_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.voice_threshold <= RST_VOICE_THRESHOLD;
         cfg_ff.flush_frames    <= RST_FLUSH_FRAMES;
         cfg_ff.break_frames    <= RST_BREAK_FRAMES;
         cfg_ff.timeout_ticks   <= RST_TIMEOUT_TICKS;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_VOICE_THRESHOLD: cfg_ff.voice_threshold <= csr_bus.data[THR_W-1:0];
            REG_FLUSH_FRAMES:    cfg_ff.flush_frames    <= csr_bus.data[FLUSH_W-1:0];
            REG_BREAK_FRAMES:    cfg_ff.break_frames    <= csr_bus.data[BREAK_W-1:0];
            REG_TIMEOUT_TICKS:   cfg_ff.timeout_ticks   <= csr_bus.data[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   evad_lane u_lane_left (
      .clock  (clock),
      .reset  (reset),
      .acc_en (pair),
      .clear  (chunk_done),
      .sample (req_bus.sample_left),
      .sum_in (left_sum)
   );

   evad_lane u_lane_right (
      .clock  (clock),
      .reset  (reset),
      .acc_en (pair),
      .clear  (chunk_done),
      .sample (req_bus.sample_right),
      .sum_in (right_sum)
   );

   evad_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (pair && chunk_done),
      .dividend (chunk_sum),
      .divisor  (frames_in),
      .result   (div_res)
   );

   evad_events u_events (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .tick    (tick),
      .div_res (div_res),
      .busy    (ev_busy),
      .rsp_bus (rsp_bus)
   );

   a_frames_bound: assert property (@(posedge clock) disable iff (reset)
      frames_ff < CHUNK_W'(MAX_CHUNK_FRAMES))
      else $error("chunk frame count reached the chunk limit without ending");
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (pair && chunk_done) |-> frames_in != '0)
      else $error("chunk ended with zero frames");
   a_chunk_restart: assert property (@(posedge clock) disable iff (reset)
      (pair && chunk_done) |=> frames_ff == '0 && !req_bus.ready)
      else $error("chunk end did not restart the frame count or stall input");

endmodule

>>> tb/tb_top.sv
module tb_top;
   import evad_pkg::*;

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 12;
   localparam int MAX_WAIT       = 6;
   localparam int SETTLE_CYCLES  = 48;
   localparam int CYCLE_LIMIT    = 3000000;
   localparam int MAX_SHOWN      = 10;
   localparam int RANDOM_ITEMS   = 230;
   localparam int RANDOM_PHASES  = 4;
   localparam int CHUNK_LIMIT    = DEF_MAX_CHUNK_FRAMES;
   localparam int LOUD_PAIRS     = 4;
   localparam int LOUD_TICKS     = 8;

   localparam int unsigned BUF_MAX   = (1 << BUF_W) - 1;
   localparam int unsigned SINCE_MAX = (1 << SINCE_W) - 1;
   localparam int unsigned TICK_MAX  = (1 << TICK_W) - 1;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LOW  = 8'd4;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_HIGH = 8'd255;

   typedef enum logic {
      FUNC_PAIR = 1'b0,
      FUNC_TICK = 1'b1
   } vad_func_type;

   typedef struct {
      bit                         is_write;
      logic                       func;
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       chunk_end;
      logic [CSR_IDX_W-1:0]       index;
      logic [CSR_DATA_W-1:0]      data;
   } stim_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BUF_W-1:0]  frames;
      logic [AVG_W-1:0]  average;
      logic              last;
   } vad_event_type;

   logic clock = 1'b0;
   logic reset;

   evad_req_if req_bus ();
   evad_rsp_if rsp_bus ();
   evad_csr_if csr_bus ();

   energy_voice_activity_detector DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #HALF_PERIOD clock = ~clock;

   stim_type      pending_items [$];
   vad_event_type expected_events [$];
   int            items_queued = 0;
   int            errors = 0;
   int            cycles;

   // handshake bookkeeping: *_taken advance at posedge, *_done at negedge
   int req_taken = 0, req_done = 0;
   int csr_taken = 0, csr_done = 0;
   int rsp_taken = 0, rsp_done = 0;

   stim_type cur_item;
   bit       holding = 0;
   int       idle_left = 0;
   int       settle = 0;
   int       source_calm = 0;
   int       sink_calm = 0;
   int       stall = 0;

   // detector copy: registers and counters
   int unsigned thr_reg     = RST_VOICE_THRESHOLD;
   int unsigned flush_reg   = RST_FLUSH_FRAMES;
   int unsigned break_reg   = RST_BREAK_FRAMES;
   int unsigned timeout_reg = RST_TIMEOUT_TICKS;
   int unsigned amp_sum     = 0;
   int unsigned chunk_count = 0;
   bit          session_open = 0;
   int unsigned buffered    = 0;
   int unsigned since_break = 0;
   int unsigned quiet_ticks = 0;

   function automatic int unsigned magnitude(logic [SAMPLE_W-1:0] s);
      return s[SAMPLE_W-1] ? (32'h10000 - s) : s;
   endfunction

   function automatic int unsigned sat_add(int unsigned a, int unsigned b, int unsigned top);
      return (a + b > top) ? top : a + b;
   endfunction

   function automatic vad_event_type make_event(logic [KIND_W-1:0] kind, int unsigned frames,
                                                int unsigned avg);
      vad_event_type e;
      e.kind    = kind;
      e.frames  = BUF_W'(frames);
      e.average = AVG_W'(avg);
      e.last    = 1'b0;
      return e;
   endfunction

   task automatic apply_write(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      case (index)
         REG_VOICE_THRESHOLD: thr_reg     = data[THR_W-1:0];
         REG_FLUSH_FRAMES:    flush_reg   = data[FLUSH_W-1:0];
         REG_BREAK_FRAMES:    break_reg   = data[BREAK_W-1:0];
         REG_TIMEOUT_TICKS:   timeout_reg = data[TIMEOUT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic predict_events(stim_type it);
      vad_event_type chunk_events [$];
      int unsigned   frames;
      int unsigned   avg;
      if (it.func == FUNC_TICK) begin
         quiet_ticks = sat_add(quiet_ticks, 1, TICK_MAX);
         return;
      end
      amp_sum += magnitude(it.left) + magnitude(it.right);
      chunk_count++;
      if (!it.chunk_end && chunk_count < CHUNK_LIMIT)
         return;
      frames      = chunk_count;
      avg         = amp_sum / frames;
      amp_sum     = 0;
      chunk_count = 0;
      buffered    = sat_add(buffered, frames, BUF_MAX);
      since_break = sat_add(since_break, frames, SINCE_MAX);
      if (avg > thr_reg) begin
         quiet_ticks = 0;
         if (!session_open) begin
            chunk_events.push_back(make_event(EV_START, 0, avg));
            session_open = 1;
         end
      end
      if (session_open && buffered > flush_reg) begin
         chunk_events.push_back(make_event(EV_FLUSH, buffered, avg));
         buffered = 0;
      end
      if (since_break > break_reg && avg < (thr_reg * 3) / 8) begin
         chunk_events.push_back(make_event(EV_BREAK, 0, avg));
         since_break = 0;
      end
      if (quiet_ticks >= timeout_reg) begin
         if (session_open)
            chunk_events.push_back(make_event(EV_END, 0, avg));
         session_open = 0;
         buffered     = 0;
         since_break  = 0;
         quiet_ticks  = 0;
      end
      if (chunk_events.size() > 0)
         chunk_events[chunk_events.size()-1].last = 1'b1;
      foreach (chunk_events[i])
         expected_events.push_back(chunk_events[i]);
   endtask

   task automatic note_error(string msg);
      errors++;
      if (errors <= MAX_SHOWN)
         $display("%s", msg);
   endtask

   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // stimulus builders
   task automatic queue_pair(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r, logic ce);
      stim_type it;
      it.is_write  = 0;
      it.func      = FUNC_PAIR;
      it.left      = l;
      it.right     = r;
      it.chunk_end = ce;
      it.index     = '0;
      it.data      = '0;
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic queue_ticks(int n);
      stim_type it;
      for (int i = 0; i < n; i++) begin
         it.is_write  = 0;
         it.func      = FUNC_TICK;
         it.left      = SAMPLE_W'($urandom);
         it.right     = SAMPLE_W'($urandom);
         it.chunk_end = 1'($urandom);
         it.index     = '0;
         it.data      = '0;
         pending_items.push_back(it);
         items_queued++;
      end
   endtask

   task automatic queue_write(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      stim_type it;
      it.is_write  = 1;
      it.func      = FUNC_PAIR;
      it.left      = '0;
      it.right     = '0;
      it.chunk_end = 1'b0;
      it.index     = index;
      it.data      = data;
      pending_items.push_back(it);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(int unsigned top);
      int unsigned a;
      if (top > 32767)
         top = 32767;
      a = $urandom_range(0, top);
      return $urandom_range(0, 1) ? SAMPLE_W'(0 - a) : SAMPLE_W'(a);
   endfunction

   task automatic queue_random_chunk(int unsigned thr);
      int unsigned len;
      int unsigned style;
      int unsigned top;
      len   = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      style = $urandom_range(0, 3);
      case (style)
         0:       top = (thr * 3) / 16;
         1:       top = thr;
         default: top = 32767;
      endcase
      for (int i = 0; i < len; i++) begin
         if (style == 3)
            queue_pair(SAMPLE_W'($urandom), SAMPLE_W'($urandom), i == len - 1);
         else
            queue_pair(pick_sample(top), pick_sample(top), i == len - 1);
      end
   endtask

   // driver: request and register channels
   always @(negedge clock) begin : driver
      logic put_req;
      logic put_csr;
      put_req = req_bus.valid;
      put_csr = csr_bus.valid;
      if (!reset) begin
         if (put_req && req_taken != req_done) begin
            put_req = 1'b0;
            req_done++;
         end
         if (put_csr && csr_taken != csr_done) begin
            put_csr = 1'b0;
            csr_done++;
         end
         if (!put_req && !put_csr) begin
            if (!holding && pending_items.size() > 0) begin
               cur_item  = pending_items.pop_front();
               holding   = 1;
               idle_left = draw_wait(source_calm);
               settle    = 0;
            end
            if (holding) begin
               if (idle_left > 0) begin
                  idle_left--;
               end else if (!cur_item.is_write) begin
                  req_bus.func         <= cur_item.func;
                  req_bus.sample_left  <= cur_item.left;
                  req_bus.sample_right <= cur_item.right;
                  req_bus.chunk_end    <= cur_item.chunk_end;
                  put_req = 1'b1;
                  holding = 0;
               end else if (expected_events.size() != 0) begin
                  settle = 0;
               end else if (settle < SETTLE_CYCLES) begin
                  // let a silent chunk finish its evaluation
                  settle++;
               end else begin
                  csr_bus.index <= cur_item.index;
                  csr_bus.data  <= cur_item.data;
                  put_csr = 1'b1;
                  holding = 0;
               end
            end
         end
      end
      req_bus.valid <= put_req;
      csr_bus.valid <= put_csr;
   end

   // receiver pacing
   always @(negedge clock) begin : sink_pacer
      logic put_ready;
      put_ready = rsp_bus.ready;
      if (!reset) begin
         if (put_ready && rsp_taken != rsp_done) begin
            rsp_done++;
            stall     = draw_wait(sink_calm);
            put_ready = (stall == 0);
         end else if (!put_ready) begin
            if (stall > 0)
               stall--;
            put_ready = (stall == 0);
         end
      end
      rsp_bus.ready <= put_ready;
   end

   // monitor: predict on accepted transactions, check returned events
   always @(posedge clock) begin : monitor
      vad_event_type seen;
      vad_event_type want;
      stim_type      taken;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.kind    = rsp_bus.event_kind;
            seen.frames  = rsp_bus.flushed_frames;
            seen.average = rsp_bus.chunk_average;
            seen.last    = rsp_bus.last_event;
            if (expected_events.size() == 0) begin
               note_error($sformatf("event %0d unexpected: kind %0d frames %0d average %0d last %0d",
                                    rsp_taken, seen.kind, seen.frames, seen.average,
                                    seen.last));
            end else begin
               want = expected_events.pop_front();
               if (seen.kind !== want.kind || seen.frames !== want.frames ||
                   seen.average !== want.average || seen.last !== want.last)
                  note_error($sformatf({"event %0d mismatch (expected/actual): kind %0d/%0d ",
                                        "frames %0d/%0d average %0d/%0d last %0d/%0d"},
                                       rsp_taken, want.kind, seen.kind, want.frames,
                                       seen.frames, want.average, seen.average, want.last,
                                       seen.last));
            end
            rsp_taken++;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            apply_write(csr_bus.index, csr_bus.data);
            csr_taken++;
         end
         if (req_bus.valid && req_bus.ready) begin
            taken.is_write  = 0;
            taken.func      = req_bus.func;
            taken.left      = req_bus.sample_left;
            taken.right     = req_bus.sample_right;
            taken.chunk_end = req_bus.chunk_end;
            taken.index     = '0;
            taken.data      = '0;
            predict_events(taken);
            req_taken++;
         end
      end
   end

   initial begin : watchdog
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
         @(posedge clock);
      $display("tb_top NOT OK");
      $finish;
   end

   initial begin : main
      int unsigned thr;
      int          goal;

      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.func         = FUNC_PAIR;
      req_bus.sample_left  = '0;
      req_bus.sample_right = '0;
      req_bus.chunk_end    = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = '0;
      csr_bus.data         = '0;
      rsp_bus.ready        = 1'b0;

      // reset register values: a loud chunk opens a session, a silent one does nothing
      queue_pair(16'sd32767, 16'sd32767, 1'b1);
      queue_pair(16'sd0, 16'sd0, 1'b1);

      // small levels so every event kind shows up in a few transactions
      queue_write(REG_VOICE_THRESHOLD, 20'd100);
      queue_write(REG_FLUSH_FRAMES, 20'd3);
      queue_write(REG_BREAK_FRAMES, 20'd4);
      queue_write(REG_TIMEOUT_TICKS, 20'd3);
      queue_write(REG_UNUSED_LOW, 20'hFFFFF);
      queue_pair(16'sd32767, -16'sd32768, 1'b0);
      queue_pair(-16'sd32768, 16'sd32767, 1'b1);
      queue_pair(16'sd100, 16'sd100, 1'b0);
      queue_pair(-16'sd101, -16'sd101, 1'b1);
      queue_pair(16'sd1, -16'sd1, 1'b1);
      queue_ticks(3);
      queue_pair(16'sd0, 16'sd0, 1'b1);
      queue_ticks(3);
      queue_pair(16'sd0, 16'sd0, 1'b1);
      // average equal to threshold is not voice, one above is
      queue_pair(16'sd50, 16'sd50, 1'b1);
      queue_pair(16'sd51, 16'sd50, 1'b1);
      // break level edge: 36 below, 37 at floor(100*3/8)
      queue_pair(16'sd18, 16'sd18, 1'b1);
      queue_pair(16'sd18, 16'sd19, 1'b1);

      // zero levels: a zero timeout ends the session at every chunk end
      queue_write(REG_VOICE_THRESHOLD, 20'h00000);
      queue_write(REG_FLUSH_FRAMES, 20'h00000);
      queue_write(REG_BREAK_FRAMES, 20'h00000);
      queue_write(REG_TIMEOUT_TICKS, 20'h00000);
      queue_pair(16'sd0, 16'sd0, 1'b1);
      queue_pair(16'sd1, 16'sd0, 1'b1);
      queue_pair(-16'sd32768, -16'sd32768, 1'b1);
      queue_ticks(1);
      queue_pair(16'sd0, 16'sd0, 1'b1);

      // top levels: a full-scale chunk averages 2^16, just above the top threshold
      queue_write(REG_VOICE_THRESHOLD, 20'hFFFFF);
      queue_write(REG_FLUSH_FRAMES, 20'hFFFFF);
      queue_write(REG_BREAK_FRAMES, 20'hFFFFF);
      queue_write(REG_TIMEOUT_TICKS, 20'hFFFFF);
      queue_write(REG_UNUSED_HIGH, 20'd0);
      for (int i = 0; i < LOUD_PAIRS; i++)
         queue_pair(-16'sd32768, -16'sd32768, i == LOUD_PAIRS - 1);
      queue_ticks(LOUD_TICKS);
      queue_pair(SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'b1);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         thr = $urandom_range(64, 4000);
         queue_write(REG_VOICE_THRESHOLD, {4'($urandom), 16'(thr)});
         queue_write(REG_FLUSH_FRAMES, {4'($urandom), 16'($urandom_range(0, 24))});
         queue_write(REG_BREAK_FRAMES, 20'($urandom_range(0, 40)));
         queue_write(REG_TIMEOUT_TICKS, {4'($urandom), 16'($urandom_range(0, 10))});
         goal = items_queued + RANDOM_ITEMS / RANDOM_PHASES;
         while (items_queued < goal) begin
            queue_ticks(($urandom_range(0, 5) == 0) ? $urandom_range(4, 12)
                                                    : $urandom_range(0, 3));
            if ($urandom_range(0, 7) == 0)
               queue_pair(SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'($urandom));
            else
               queue_random_chunk(thr);
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || holding || req_bus.valid || csr_bus.valid ||
             expected_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_events.size() != 0)
         note_error($sformatf("%0d expected events never arrived", expected_events.size()));

      if (errors == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
